FILE: rtl/saw_pkg.sv
package saw_pkg;

	localparam int unsigned MAX_PAYLOAD = 1023;

	localparam int unsigned LEN_W = 10;
	localparam int unsigned CNT_W = 11;
	localparam int unsigned SUM_W = 18;
	localparam int unsigned ATT_W = 8;
	localparam int unsigned TICK_W = 16;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned S_DATA_W = 104;
	localparam int unsigned M_DATA_W = 40;

	localparam logic [31:0] ACK_KIND = 32'd2;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	localparam logic [ATT_W-1:0] MAX_ATTEMPTS_RST = 8'd10;
	localparam logic [TICK_W-1:0] ACK_TIMEOUT_RST = 16'd2;

	typedef enum logic [2:0] {
		OP_BYTE = 3'd0,
		OP_FRAME = 3'd1,
		OP_TICK = 3'd2,
		OP_LINK_LOST = 3'd3,
		OP_RECONNECT_FAIL = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_SEND = 2'd0,
		ST_DELIVERED = 2'd1,
		ST_FAILED = 2'd2,
		ST_REJECTED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1
	} phase_t;

	typedef enum logic {
		CFG_MAX_ATTEMPTS = 1'b0,
		CFG_ACK_TIMEOUT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] data_byte;
		logic last_byte;
		logic [31:0] frame_kind;
		logic [31:0] frame_seq;
		logic [31:0] frame_len;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic seq_bit;
		logic [LEN_W-1:0] payload_len;
		logic [SUM_W-1:0] sum_value;
		logic [ATT_W-1:0] attempt_no;
		logic need_reconnect;
	} result_t;

endpackage

FILE: rtl/stop_and_wait_arq_sender.sv
// Stop-and-wait ARQ sender. The message state is updated at the edge that accepts a word, and
// any result is placed in a two-entry output register, so a new word may be accepted every cycle
// as long as that register is not full (s_tready drops only when two results are waiting).
// Payload bytes (tuser 0) accumulate length and checksum; the byte with tlast set issues the
// first DATA request, or rejects a payload over 1023 bytes. Received headers, ticks, link loss
// and reconnect failure then drive retransmission, delivery or failure, one result at most
// per input word. Configuration writes are taken at any time but are meant for idle periods.
module stop_and_wait_arq_sender (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [0:0] cfg_index,
	input logic [saw_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// data_byte, frame_kind, frame_seq, frame_len
	input logic [saw_pkg::S_DATA_W-1:0] s_tdata,
	// operation
	input logic [2:0] s_tuser,
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	// seq_bit, payload_len, sum_value, attempt_no, need_reconnect, 2 zero bits
	output logic [saw_pkg::M_DATA_W-1:0] m_tdata,
	// status
	output logic [1:0] m_tuser
);
	import saw_pkg::*;

	item_t item;
	logic accept;
	logic res_valid;
	result_t res;
	result_t out_res;

	assign item.operation = s_tuser;
	assign item.data_byte = s_tdata[7:0];
	assign item.last_byte = s_tlast;
	assign item.frame_kind = s_tdata[39:8];
	assign item.frame_seq = s_tdata[71:40];
	assign item.frame_len = s_tdata[103:72];

	assign accept = s_tvalid & s_tready;

	saw_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_idx_t'(cfg_index)),
		.cfg_data(cfg_data),
		.item_valid(accept),
		.item(item),
		.res_valid(res_valid),
		.res(res)
	);

	saw_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept & res_valid),
		.push_data(res),
		.space(s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(out_res)
	);

	assign m_tuser = out_res.status;
	assign m_tdata = {2'b00, out_res.need_reconnect, out_res.attempt_no,
		out_res.sum_value, out_res.payload_len, out_res.seq_bit};

endmodule

FILE: rtl/saw_core.sv
module saw_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input saw_pkg::cfg_idx_t cfg_index,
	input logic [saw_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic item_valid,
	input saw_pkg::item_t item,
	output logic res_valid,
	output saw_pkg::result_t res
);
	import saw_pkg::*;

	logic [ATT_W-1:0] max_attempts_q;
	logic [TICK_W-1:0] ack_timeout_q;

	phase_t phase_q, phase_d;
	logic seq_q, seq_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [SUM_W-1:0] sum_q, sum_d;
	logic [ATT_W-1:0] att_q, att_d;
	logic [TICK_W-1:0] ticks_q, ticks_d;
	logic too_long_q, too_long_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_attempts_q <= MAX_ATTEMPTS_RST;
			ack_timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_MAX_ATTEMPTS: max_attempts_q <= cfg_data[ATT_W-1:0];
				CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			seq_q <= 1'b0;
			count_q <= '0;
			sum_q <= '0;
			att_q <= '0;
			ticks_q <= '0;
			too_long_q <= 1'b0;
		end else if (item_valid) begin
			phase_q <= phase_d;
			seq_q <= seq_d;
			count_q <= count_d;
			sum_q <= sum_d;
			att_q <= att_d;
			ticks_q <= ticks_d;
			too_long_q <= too_long_d;
		end
	end

	logic [CNT_W-1:0] count_inc;
	logic [TICK_W-1:0] ticks_inc;
	logic retx;
	logic retx_rc;
	logic fin;
	status_t fin_status;

	always_comb begin
		phase_d = phase_q;
		seq_d = seq_q;
		count_d = count_q;
		sum_d = sum_q;
		att_d = att_q;
		ticks_d = ticks_q;
		too_long_d = too_long_q;
		res_valid = 1'b0;
		res = '0;
		retx = 1'b0;
		retx_rc = 1'b0;
		fin = 1'b0;
		fin_status = ST_FAILED;

		count_inc = (count_q <= CNT_W'(MAX_PAYLOAD)) ? count_q + CNT_W'(1) : count_q;
		ticks_inc = (ticks_q < TICK_MAX) ? ticks_q + TICK_W'(1) : ticks_q;

		if (phase_q != PH_WAIT) begin
			if (item.operation == OP_BYTE) begin
				count_d = count_inc;
				if (count_inc > CNT_W'(MAX_PAYLOAD))
					too_long_d = 1'b1;
				sum_d = sum_q + SUM_W'(item.data_byte);
				if (item.last_byte) begin
					res_valid = 1'b1;
					if (too_long_d) begin
						res.status = ST_REJECTED;
						res.seq_bit = seq_q;
						phase_d = PH_IDLE;
						count_d = '0;
						sum_d = '0;
						att_d = '0;
						ticks_d = '0;
						too_long_d = 1'b0;
					end else begin
						phase_d = PH_WAIT;
						att_d = ATT_W'(1);
						ticks_d = '0;
						res.status = ST_SEND;
						res.seq_bit = seq_q;
						res.payload_len = count_d[LEN_W-1:0];
						res.sum_value = sum_d;
						res.attempt_no = ATT_W'(1);
					end
				end
			end
		end else begin
			case (item.operation)
				OP_FRAME: begin
					if (item.frame_len > 32'(MAX_PAYLOAD)) begin
						retx = 1'b1;
						retx_rc = 1'b1;
					end else if (item.frame_kind == ACK_KIND &&
							item.frame_seq == {31'b0, seq_q}) begin
						fin = 1'b1;
						fin_status = ST_DELIVERED;
					end else begin
						retx = 1'b1;
					end
				end
				OP_TICK: begin
					ticks_d = ticks_inc;
					if (ticks_inc >= ack_timeout_q)
						retx = 1'b1;
				end
				OP_LINK_LOST: begin
					retx = 1'b1;
					retx_rc = 1'b1;
				end
				OP_RECONNECT_FAIL: begin
					fin = 1'b1;
				end
				default: ;
			endcase

			if (retx) begin
				if (att_q >= max_attempts_q) begin
					fin = 1'b1;
				end else begin
					att_d = att_q + ATT_W'(1);
					ticks_d = '0;
					res_valid = 1'b1;
					res.status = ST_SEND;
					res.seq_bit = seq_q;
					res.payload_len = count_q[LEN_W-1:0];
					res.sum_value = sum_q;
					res.attempt_no = att_d;
					res.need_reconnect = retx_rc;
				end
			end

			if (fin) begin
				res_valid = 1'b1;
				res.status = fin_status;
				res.seq_bit = seq_q;
				res.payload_len = count_q[LEN_W-1:0];
				res.sum_value = sum_q;
				res.attempt_no = att_q;
				res.need_reconnect = 1'b0;
				if (fin_status == ST_DELIVERED)
					seq_d = ~seq_q;
				phase_d = PH_IDLE;
				count_d = '0;
				sum_d = '0;
				att_d = '0;
				ticks_d = '0;
				too_long_d = 1'b0;
			end
		end
	end

endmodule

FILE: rtl/saw_out.sv
module saw_out (
	input logic clk,
	input logic arst_n,
	input logic push,
	input saw_pkg::result_t push_data,
	output logic space,
	output logic out_valid,
	input logic out_ready,
	output saw_pkg::result_t out_data
);
	import saw_pkg::*;

	logic main_valid_q;
	logic skid_valid_q;
	result_t main_q;
	result_t skid_q;

	assign space = ~skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || out_ready) begin
			main_valid_q <= skid_valid_q | push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || out_ready) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule
